// ===== rtl/vcd_pkg.sv =====
// Shared types, constants and denomination tables of the vending change dispenser.
// No dependencies; every other file of the block refers to this package by scoped names.

package vcd_pkg;

  localparam int TOTAL_BITS_DEF = 24;
  localparam int PRICE_W        = 16;
  localparam int AMOUNT_W       = 16;
  localparam int PRODUCT_W      = 8;
  localparam int DENOM_W        = 14;
  localparam int COUNT_W        = 11;
  localparam int NUM_DENOMS     = 12;
  localparam int DENOM_IDX_W    = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int NOTE_SUM_W     = 23;

  localparam logic [CFG_IDX_W-1:0] REG_PRICE_ONE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRICE_TWO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRICE_THREE = 2'd2;

  localparam logic [PRICE_W-1:0] PRICE_ONE_RST   = 16'd430;
  localparam logic [PRICE_W-1:0] PRICE_TWO_RST   = 16'd270;
  localparam logic [PRICE_W-1:0] PRICE_THREE_RST = 16'd143;

  localparam logic [PRODUCT_W-1:0] PRODUCT_ONE   = 8'd1;
  localparam logic [PRODUCT_W-1:0] PRODUCT_TWO   = 8'd2;
  localparam logic [PRODUCT_W-1:0] PRODUCT_THREE = 8'd3;

  localparam logic CMD_SELECT = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;
  localparam logic [DENOM_W:0]   TOP_DENOM = 15'd10000;

  typedef enum logic [1:0] {
    STATUS_CHANGE     = 2'd0,
    STATUS_NO_CHANGE  = 2'd1,
    STATUS_SHORT      = 2'd2,
    STATUS_NO_PRODUCT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STATUS,
    ST_DIVIDE,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic walk_step;
    logic emit_status;
    logic emit_change;
  } vcd_cmd_t;

  typedef struct packed {
    logic    settle;
    status_t settle_code;
    logic    div_done;
    logic    slot_free;
    logic    walk_zero;
    logic    walk_last;
  } vcd_stat_t;

  function automatic logic [DENOM_W-1:0] denom_value(input logic [DENOM_IDX_W-1:0] idx);
    logic [DENOM_W-1:0] v;
    unique case (idx)
      4'd0:    v = 14'd10000;
      4'd1:    v = 14'd5000;
      4'd2:    v = 14'd2000;
      4'd3:    v = 14'd1000;
      4'd4:    v = 14'd500;
      4'd5:    v = 14'd200;
      4'd6:    v = 14'd100;
      4'd7:    v = 14'd50;
      4'd8:    v = 14'd25;
      4'd9:    v = 14'd10;
      4'd10:   v = 14'd5;
      default: v = 14'd1;
    endcase
    return v;
  endfunction

  // The six largest denominations are notes, the rest are coins.
  function automatic logic denom_is_note(input logic [DENOM_IDX_W-1:0] idx);
    return (idx < 4'd6);
  endfunction

endpackage

// ===== rtl/vcd_if.sv =====
// Valid/ready channel interfaces of the vending change dispenser: request and result.
// Depends on vcd_pkg for field widths.

interface vcd_req_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic [vcd_pkg::PRODUCT_W-1:0]  product_number;
  logic                           is_note;
  logic [vcd_pkg::AMOUNT_W-1:0]   amount;

  modport source(output valid, cmd, product_number, is_note, amount, input ready);
  modport sink(input valid, cmd, product_number, is_note, amount, output ready);
endinterface

interface vcd_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic                           change_is_note;
  logic [vcd_pkg::DENOM_W-1:0]    denomination_cents;
  logic [vcd_pkg::COUNT_W-1:0]    item_count;
  logic                           last;

  modport source(output valid, status, change_is_note, denomination_cents, item_count, last,
                 input ready);
  modport sink(input valid, status, change_is_note, denomination_cents, item_count, last,
               output ready);
endinterface

// ===== rtl/vending_change_dispenser_core.sv =====
// Vending change dispenser top level: controller, datapath and channel hookup.
// Depends on vcd_pkg, vcd_if, vcd_ctrl and vcd_datapath.
//
// Usage:
//   req carries one item per handshake: a select (cmd 0) sets the price of
//   product 1 to 3 from the price registers, or no product otherwise; an insert
//   (cmd 1) with nonzero amount adds cents, or amount times 100 for notes, to a
//   total that saturates at 2^TOTAL_BITS - 1; an insert of amount 0 settles.
//   rsp carries the results of a settlement: one status result, or one change
//   result per denomination used from 10000 down to 1 cent, the final one with
//   last set. Prices are written through cfg_we / cfg_index / cfg_wdata.
// Timing:
//   Select and insert items are taken at one per cycle. A settlement with a
//   status result waits in ST_STATUS for a free result register, loads the status
//   into it and returns to ST_IDLE for the next item. A settlement with change
//   divides by 10000 through a reciprocal multiplication, quotient then remainder,
//   then walks one denomination per cycle, waiting for a free result register only
//   at used ones; the next item is taken once the last change result is loaded.
// Reset clears selection and total and loads the default prices. When the
//   receiver stalls, the result register holds and the walk waits at the next used denomination.

module vending_change_dispenser_core #(
  parameter int TOTAL_BITS = vcd_pkg::TOTAL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [vcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vcd_pkg::PRICE_W-1:0]   cfg_wdata,
  vcd_req_if.sink                       req,
  vcd_rsp_if.source                     rsp
);

  vcd_pkg::vcd_cmd_t  cmd;
  vcd_pkg::vcd_stat_t stat;

  vcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  vcd_datapath #(
    .TOTAL_BITS (TOTAL_BITS)
  ) u_datapath (
    .clk                    (clk),
    .rst                    (rst),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .req_cmd                (req.cmd),
    .req_product_number     (req.product_number),
    .req_is_note            (req.is_note),
    .req_amount             (req.amount),
    .cmd                    (cmd),
    .stat                   (stat),
    .rsp_ready              (rsp.ready),
    .rsp_valid              (rsp.valid),
    .rsp_status             (rsp.status),
    .rsp_change_is_note     (rsp.change_is_note),
    .rsp_denomination_cents (rsp.denomination_cents),
    .rsp_item_count         (rsp.item_count),
    .rsp_last               (rsp.last)
  );

endmodule

// ===== rtl/vcd_ctrl.sv =====
// Controller state machine of the vending change dispenser.
// Depends on vcd_pkg for the state, command and status types.

module vcd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output vcd_pkg::vcd_cmd_t  cmd,
  input  vcd_pkg::vcd_stat_t stat
);

  vcd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vcd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      vcd_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          if (stat.settle) begin
            if (stat.settle_code == vcd_pkg::STATUS_CHANGE) begin
              state_next = vcd_pkg::ST_DIVIDE;
            end else begin
              state_next = vcd_pkg::ST_STATUS;
            end
          end
        end
      end
      vcd_pkg::ST_STATUS: begin
        if (stat.slot_free) begin
          cmd.emit_status = 1'b1;
          state_next      = vcd_pkg::ST_IDLE;
        end
      end
      vcd_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = vcd_pkg::ST_WALK;
        end
      end
      vcd_pkg::ST_WALK: begin
        // Unused denominations are skipped without waiting for the output slot.
        if (stat.walk_zero) begin
          cmd.walk_step = 1'b1;
        end else if (stat.slot_free) begin
          cmd.walk_step   = 1'b1;
          cmd.emit_change = 1'b1;
          if (stat.walk_last) begin
            state_next = vcd_pkg::ST_IDLE;
          end
        end
      end
    endcase
  end

endmodule

// ===== rtl/vcd_datapath.sv =====
// Datapath of the vending change dispenser: price registers, running total,
// division by the largest note through a reciprocal multiplication, denomination walk
// and result register. Depends on vcd_pkg.

module vcd_datapath #(
  parameter int TOTAL_BITS = vcd_pkg::TOTAL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [vcd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vcd_pkg::PRICE_W-1:0]       cfg_wdata,
  input  logic                              req_cmd,
  input  logic [vcd_pkg::PRODUCT_W-1:0]     req_product_number,
  input  logic                              req_is_note,
  input  logic [vcd_pkg::AMOUNT_W-1:0]      req_amount,
  input  vcd_pkg::vcd_cmd_t                 cmd,
  output vcd_pkg::vcd_stat_t                stat,
  input  logic                              rsp_ready,
  output logic                              rsp_valid,
  output logic [1:0]                        rsp_status,
  output logic                              rsp_change_is_note,
  output logic [vcd_pkg::DENOM_W-1:0]       rsp_denomination_cents,
  output logic [vcd_pkg::COUNT_W-1:0]       rsp_item_count,
  output logic                              rsp_last
);

  // 2^13 < 10000, so the quotient by the largest note fits in TOTAL_BITS - 13 bits.
  localparam int QW     = TOTAL_BITS - 13;
  localparam int SUM_W  = ((TOTAL_BITS > vcd_pkg::NOTE_SUM_W) ? TOTAL_BITS
                                                              : vcd_pkg::NOTE_SUM_W) + 1;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
  // 10000 is 16 times 625: the change is shifted right by four and multiplied by
  // the rounded-up reciprocal 2^38 / 625, which is exact for dividends below 2^28.
  localparam int TW          = TOTAL_BITS - 4;
  localparam int RECIP_SHIFT = 38;
  localparam int PROD_W      = TW + 29;
  localparam logic [28:0] RECIP_625 = 29'd439804652;

  logic [vcd_pkg::PRICE_W-1:0]    price_one, price_two, price_three;
  logic [vcd_pkg::PRICE_W-1:0]    selected_price;
  logic [TOTAL_BITS-1:0]          total;

  logic [vcd_pkg::PRICE_W-1:0]    price_sel;
  logic [vcd_pkg::NOTE_SUM_W-1:0] note_value;
  logic [vcd_pkg::NOTE_SUM_W-1:0] add_value;
  logic [SUM_W-1:0]               sum;
  logic [TOTAL_BITS-1:0]          total_sat;
  logic [TOTAL_BITS-1:0]          price_ext;
  logic [TOTAL_BITS-1:0]          change;
  vcd_pkg::status_t               settle_code;

  vcd_pkg::status_t               settle_status;
  logic [TOTAL_BITS-1:0]          owed;
  logic [vcd_pkg::DENOM_W-1:0]    rem;
  logic [QW-1:0]                  quo;
  logic                           div_phase;
  logic [vcd_pkg::DENOM_IDX_W-1:0] idx;

  logic [PROD_W-1:0]              recip_prod;
  logic [TOTAL_BITS-1:0]          quo_scaled;
  logic [TOTAL_BITS-1:0]          div_rem;
  logic [31:0]                    quo_ext;
  logic [vcd_pkg::COUNT_W-1:0]    quo_sat;

  logic [vcd_pkg::DENOM_W-1:0]    dval;
  logic [15:0]                    m1, m2, m3, m4, rem16;
  logic [vcd_pkg::COUNT_W-1:0]    walk_count;
  logic [vcd_pkg::DENOM_W-1:0]    walk_rem;
  logic [15:0]                    walk_sub;

  // ---------------- item handling ----------------
  always_comb begin
    priority if (req_product_number == vcd_pkg::PRODUCT_ONE) begin
      price_sel = price_one;
    end else if (req_product_number == vcd_pkg::PRODUCT_TWO) begin
      price_sel = price_two;
    end else if (req_product_number == vcd_pkg::PRODUCT_THREE) begin
      price_sel = price_three;
    end else begin
      price_sel = '0;
    end
  end

  // amount * 100 as 64 + 32 + 4 times amount.
  assign note_value = vcd_pkg::NOTE_SUM_W'({req_amount, 6'b0})
                    + vcd_pkg::NOTE_SUM_W'({req_amount, 5'b0})
                    + vcd_pkg::NOTE_SUM_W'({req_amount, 2'b0});
  assign add_value  = req_is_note ? note_value : vcd_pkg::NOTE_SUM_W'(req_amount);
  assign sum        = SUM_W'(total) + SUM_W'(add_value);
  assign total_sat  = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];

  assign price_ext  = TOTAL_BITS'(selected_price);
  assign change     = total - price_ext;

  always_comb begin
    priority if (selected_price == '0) begin
      settle_code = vcd_pkg::STATUS_NO_PRODUCT;
    end else if (total < price_ext) begin
      settle_code = vcd_pkg::STATUS_SHORT;
    end else if (total == price_ext) begin
      settle_code = vcd_pkg::STATUS_NO_CHANGE;
    end else begin
      settle_code = vcd_pkg::STATUS_CHANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      price_one      <= vcd_pkg::PRICE_ONE_RST;
      price_two      <= vcd_pkg::PRICE_TWO_RST;
      price_three    <= vcd_pkg::PRICE_THREE_RST;
      selected_price <= '0;
      total          <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == vcd_pkg::REG_PRICE_ONE) begin
          price_one <= cfg_wdata;
        end
        if (cfg_index == vcd_pkg::REG_PRICE_TWO) begin
          price_two <= cfg_wdata;
        end
        if (cfg_index == vcd_pkg::REG_PRICE_THREE) begin
          price_three <= cfg_wdata;
        end
      end
      if (cmd.accept) begin
        if (req_cmd == vcd_pkg::CMD_SELECT) begin
          selected_price <= price_sel;
        end else if (req_amount != '0) begin
          total <= total_sat;
        end else begin
          selected_price <= '0;
          total          <= '0;
        end
      end
    end
  end

  // ---------------- division by the largest note, quotient then remainder ----------------
  assign recip_prod = PROD_W'(owed[TOTAL_BITS-1:4]) * PROD_W'(RECIP_625);
  assign quo_scaled = TOTAL_BITS'(quo) * TOTAL_BITS'(vcd_pkg::TOP_DENOM);
  assign div_rem    = owed - quo_scaled;
  assign quo_ext    = 32'(quo);
  assign quo_sat    = (quo_ext > 32'(vcd_pkg::COUNT_MAX)) ? vcd_pkg::COUNT_MAX
                                                           : quo_ext[vcd_pkg::COUNT_W-1:0];

  // ---------------- denomination walk ----------------
  // Below the largest note the remainder never reaches five times the next
  // denomination, so the count is found from four compares.
  assign dval  = vcd_pkg::denom_value(idx);
  assign m1    = 16'(dval);
  assign m2    = {m1[14:0], 1'b0};
  assign m3    = m2 + m1;
  assign m4    = {m1[13:0], 2'b0};
  assign rem16 = 16'(rem);

  always_comb begin
    walk_sub = '0;
    if (idx == '0) begin
      walk_count = quo_sat;
    end else if (rem16 >= m4) begin
      walk_count = 11'd4;
      walk_sub   = m4;
    end else if (rem16 >= m3) begin
      walk_count = 11'd3;
      walk_sub   = m3;
    end else if (rem16 >= m2) begin
      walk_count = 11'd2;
      walk_sub   = m2;
    end else if (rem16 >= m1) begin
      walk_count = 11'd1;
      walk_sub   = m1;
    end else begin
      walk_count = '0;
    end
  end

  assign walk_rem = rem - walk_sub[vcd_pkg::DENOM_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept && stat.settle) begin
      settle_status <= settle_code;
      owed          <= change;
      rem           <= '0;
      quo           <= '0;
      div_phase     <= 1'b0;
      idx           <= '0;
    end else if (cmd.div_step) begin
      if (!div_phase) begin
        quo <= recip_prod[PROD_W-1:RECIP_SHIFT];
      end else begin
        rem <= div_rem[vcd_pkg::DENOM_W-1:0];
      end
      div_phase <= !div_phase;
    end else if (cmd.walk_step) begin
      idx <= idx + 1'b1;
      rem <= walk_rem;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit_status || cmd.emit_change) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_status) begin
      rsp_status             <= settle_status;
      rsp_change_is_note     <= 1'b0;
      rsp_denomination_cents <= '0;
      rsp_item_count         <= '0;
      rsp_last               <= 1'b1;
    end else if (cmd.emit_change) begin
      rsp_status             <= vcd_pkg::STATUS_CHANGE;
      rsp_change_is_note     <= vcd_pkg::denom_is_note(idx);
      rsp_denomination_cents <= dval;
      rsp_item_count         <= walk_count;
      rsp_last               <= (walk_rem == '0);
    end
  end

  // Once the remainder is zero every later count is zero, so this result is the last.
  assign stat.settle      = (req_cmd == vcd_pkg::CMD_INSERT) && (req_amount == '0);
  assign stat.settle_code = settle_code;
  assign stat.div_done    = div_phase;
  assign stat.slot_free   = !rsp_valid || rsp_ready;
  assign stat.walk_zero   = (walk_count == '0);
  assign stat.walk_last   = (walk_rem == '0);

endmodule

// ===== rtl/vcd_checker.sv =====
// Port-level checks of the vending change dispenser, bound to the top level.
// Depends on vcd_pkg and vending_change_dispenser_core.

module vcd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        req_cmd,
  input logic [vcd_pkg::AMOUNT_W-1:0] req_amount,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [1:0]                  rsp_status,
  input logic                        rsp_change_is_note,
  input logic [vcd_pkg::DENOM_W-1:0] rsp_denomination_cents,
  input logic [vcd_pkg::COUNT_W-1:0] rsp_item_count,
  input logic                        rsp_last
);

  logic req_settle;
  assign req_settle = req_valid && req_ready && (req_cmd == vcd_pkg::CMD_INSERT)
                      && (req_amount == '0);

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_item_count)
      && $stable(rsp_denomination_cents) && $stable(rsp_last))
    else $error("stalled result changed");

  // Selects and ordinary inserts never cause a result.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !req_settle && !rsp_valid |=> !rsp_valid)
    else $error("result appeared without a settlement");

  // A settlement blocks new items while its results are produced.
  assert property (@(posedge clk) disable iff (rst)
    req_settle |=> !req_ready)
    else $error("item taken during settlement");

  // Status results are single, final and carry no change.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != vcd_pkg::STATUS_CHANGE) |->
      rsp_last && !rsp_change_is_note && (rsp_denomination_cents == '0)
      && (rsp_item_count == '0))
    else $error("malformed status result");

  // Change results name a real denomination and a nonzero count.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == vcd_pkg::STATUS_CHANGE) |->
      (rsp_item_count != '0) && (rsp_denomination_cents != '0))
    else $error("empty change result");

endmodule

bind vending_change_dispenser_core vcd_checker u_checker (
  .clk                    (clk),
  .rst                    (rst),
  .req_valid              (req.valid),
  .req_ready              (req.ready),
  .req_cmd                (req.cmd),
  .req_amount             (req.amount),
  .rsp_valid              (rsp.valid),
  .rsp_ready              (rsp.ready),
  .rsp_status             (rsp.status),
  .rsp_change_is_note     (rsp.change_is_note),
  .rsp_denomination_cents (rsp.denomination_cents),
  .rsp_item_count         (rsp.item_count),
  .rsp_last               (rsp.last)
);

// ===== dv/vending_change_dispenser_core_test.sv =====
// Self-checking testbench of the vending change dispenser core: directed sales, then random ones.
// Needs rtl/vcd_pkg.sv, rtl/vcd_if.sv and the core; results are checked against a local predictor.

module vending_change_dispenser_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_BITS = vcd_pkg::TOTAL_BITS_DEF;
  localparam longint TOTAL_MAX = (longint'(1) << TOTAL_BITS) - 1;
  localparam int SETTLE_CYCLES = TOTAL_BITS + 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NOTE_KINDS = 6;
  localparam logic [vcd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int DENOM_CENTS [vcd_pkg::NUM_DENOMS] = '{10000, 5000, 2000, 1000, 500, 200,
                                                       100, 50, 25, 10, 5, 1};

  typedef struct packed {
    vcd_pkg::status_t            status;
    logic                        change_is_note;
    logic [vcd_pkg::DENOM_W-1:0] denomination_cents;
    logic [vcd_pkg::COUNT_W-1:0] item_count;
    logic                        last;
  } payout_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_we;
  logic [vcd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [vcd_pkg::PRICE_W-1:0]   cfg_wdata;

  vcd_req_if req_ch();
  vcd_rsp_if rsp_ch();

  vending_change_dispenser_core #(
    .TOTAL_BITS(TOTAL_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  // Predictor state: price registers, current selection and money paid in.
  logic [vcd_pkg::PRICE_W-1:0] price_tab [3];
  logic [vcd_pkg::PRICE_W-1:0] chosen_price;
  logic [TOTAL_BITS-1:0]       paid_total;
  payout_t                     payout_q [$];

  bit quiet;
  int n_items;
  int n_settles;
  int n_results;
  int n_errors;
  int idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic predict_item(input logic cmd, input logic [vcd_pkg::PRODUCT_W-1:0] product,
                              input logic is_note, input logic [vcd_pkg::AMOUNT_W-1:0] amount);
    longint  sum;
    longint  change;
    longint  counts [vcd_pkg::NUM_DENOMS];
    int      last_used;
    payout_t p;
    if (cmd == vcd_pkg::CMD_SELECT) begin
      case (product)
        vcd_pkg::PRODUCT_ONE:   chosen_price = price_tab[0];
        vcd_pkg::PRODUCT_TWO:   chosen_price = price_tab[1];
        vcd_pkg::PRODUCT_THREE: chosen_price = price_tab[2];
        default:                chosen_price = '0;
      endcase
    end else if (amount != 0) begin
      sum = longint'(paid_total) + (is_note ? longint'(amount) * 100 : longint'(amount));
      paid_total = TOTAL_BITS'((sum > TOTAL_MAX) ? TOTAL_MAX : sum);
    end else begin
      n_settles++;
      p = '0;
      p.last = 1'b1;
      if (chosen_price == 0) begin
        p.status = vcd_pkg::STATUS_NO_PRODUCT;
        payout_q.push_back(p);
      end else if (paid_total < chosen_price) begin
        p.status = vcd_pkg::STATUS_SHORT;
        payout_q.push_back(p);
      end else if (paid_total == chosen_price) begin
        p.status = vcd_pkg::STATUS_NO_CHANGE;
        payout_q.push_back(p);
      end else begin
        change = longint'(paid_total) - longint'(chosen_price);
        last_used = 0;
        for (int i = 0; i < vcd_pkg::NUM_DENOMS; i++) begin
          counts[i] = change / DENOM_CENTS[i];
          change -= counts[i] * DENOM_CENTS[i];
          if (counts[i] > vcd_pkg::COUNT_MAX) counts[i] = vcd_pkg::COUNT_MAX;
          if (counts[i] != 0) last_used = i;
        end
        for (int i = 0; i < vcd_pkg::NUM_DENOMS; i++) begin
          if (counts[i] != 0) begin
            p.status             = vcd_pkg::STATUS_CHANGE;
            p.change_is_note     = (i < NOTE_KINDS);
            p.denomination_cents = vcd_pkg::DENOM_W'(DENOM_CENTS[i]);
            p.item_count         = vcd_pkg::COUNT_W'(counts[i]);
            p.last               = (i == last_used);
            payout_q.push_back(p);
          end
        end
      end
      chosen_price = '0;
      paid_total   = '0;
    end
  endtask

  // Valid stays high when the next item follows at once; a gap lowers it at the accepting edge.
  task automatic send_item(input logic cmd, input logic [vcd_pkg::PRODUCT_W-1:0] product,
                           input logic is_note, input logic [vcd_pkg::AMOUNT_W-1:0] amount);
    req_ch.valid          <= 1'b1;
    req_ch.cmd            <= cmd;
    req_ch.product_number <= product;
    req_ch.is_note        <= is_note;
    req_ch.amount         <= amount;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_item(cmd, product, is_note, amount);
    n_items++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic select_product(input logic [vcd_pkg::PRODUCT_W-1:0] product);
    send_item(vcd_pkg::CMD_SELECT, product, 1'($urandom), 16'($urandom));
  endtask

  task automatic insert_money(input logic is_note, input logic [vcd_pkg::AMOUNT_W-1:0] amount);
    send_item(vcd_pkg::CMD_INSERT, 8'($urandom), is_note, amount);
  endtask

  task automatic settle_sale();
    send_item(vcd_pkg::CMD_INSERT, 8'($urandom), 1'($urandom), '0);
  endtask

  // Selects and inserts give no result, so a full settlement time is allowed after the last one.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (payout_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_prices(input logic [vcd_pkg::PRICE_W-1:0] p1,
                            input logic [vcd_pkg::PRICE_W-1:0] p2,
                            input logic [vcd_pkg::PRICE_W-1:0] p3);
    logic [vcd_pkg::CFG_IDX_W-1:0] idx  [4];
    logic [vcd_pkg::PRICE_W-1:0]   vals [4];
    idx  = '{vcd_pkg::REG_PRICE_ONE, vcd_pkg::REG_PRICE_TWO, vcd_pkg::REG_PRICE_THREE,
             REG_SPARE};
    vals = '{p1, p2, p3, vcd_pkg::PRICE_W'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      case (idx[i])
        vcd_pkg::REG_PRICE_ONE:   price_tab[0] = vals[i];
        vcd_pkg::REG_PRICE_TWO:   price_tab[1] = vals[i];
        vcd_pkg::REG_PRICE_THREE: price_tab[2] = vals[i];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  task automatic test_status_paths();
    settle_sale();
    select_product(vcd_pkg::PRODUCT_ONE);
    insert_money(1'b0, 16'd430);
    settle_sale();
    select_product(vcd_pkg::PRODUCT_TWO);
    insert_money(1'b0, 16'd1);
    settle_sale();
    // The failed sale must have cleared the selection.
    settle_sale();
    select_product(8'hFF);
    send_item(vcd_pkg::CMD_INSERT, 8'hFF, 1'b1, '0);
  endtask

  task automatic test_change_breakdown();
    // Reselection keeps only the later price; 18891 cents of change use every denomination.
    select_product(vcd_pkg::PRODUCT_TWO);
    select_product(vcd_pkg::PRODUCT_ONE);
    insert_money(1'b1, 16'd193);
    insert_money(1'b0, 16'd21);
    settle_sale();
  endtask

  task automatic test_total_saturation();
    select_product(vcd_pkg::PRODUCT_THREE);
    repeat (3) insert_money(1'b1, 16'hFFFF);
    insert_money(1'b0, 16'hFFFF);
    settle_sale();
  endtask

  task automatic test_price_extremes();
    wait_idle();
    set_prices(16'd1, 16'd0, 16'hFFFF);
    // A zero price register reads as a product that does not exist.
    select_product(vcd_pkg::PRODUCT_TWO);
    settle_sale();
    select_product(vcd_pkg::PRODUCT_THREE);
    insert_money(1'b0, 16'hFFFF);
    settle_sale();
  endtask

  task automatic test_random_sales(input int n_target);
    int                            start;
    int                            pick;
    int                            n_ins;
    int                            share;
    int                            amt;
    logic                          note;
    logic [vcd_pkg::PRICE_W-1:0]   price;
    logic [vcd_pkg::PRODUCT_W-1:0] prod;
    start = n_items;
    while (n_items - start < n_target) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_item(1'($urandom), 8'($urandom), 1'($urandom), 16'($urandom));
      end else begin
        prod = (pick == 1) ? 8'($urandom) : 8'($urandom_range(1, 3));
        // Now and then a sale starts without any selection.
        if (pick != 2) select_product(prod);
        case (prod)
          vcd_pkg::PRODUCT_ONE:   price = price_tab[0];
          vcd_pkg::PRODUCT_TWO:   price = price_tab[1];
          vcd_pkg::PRODUCT_THREE: price = price_tab[2];
          default:                price = 16'd500;
        endcase
        if (price == 0) price = 16'd500;
        n_ins = $urandom_range(1, 4);
        share = price / n_ins;
        repeat (n_ins) begin
          note = ($urandom_range(0, 2) == 0);
          if (note) amt = $urandom_range(1, share / 100 + 2);
          else amt = $urandom_range(1, share + share / 2 + 3);
          if (amt > 65535) amt = 65535;
          insert_money(note, vcd_pkg::AMOUNT_W'(amt));
        end
        if ($urandom_range(0, 7) == 0) select_product(8'($urandom_range(1, 3)));
        settle_sale();
      end
    end
  endtask

  initial begin
    quiet     = 1'b0;
    n_items   = 0;
    n_settles = 0;
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= vcd_pkg::REG_PRICE_ONE;
    cfg_wdata             <= '0;
    req_ch.valid          <= 1'b0;
    req_ch.cmd            <= vcd_pkg::CMD_SELECT;
    req_ch.product_number <= '0;
    req_ch.is_note        <= 1'b0;
    req_ch.amount         <= '0;
    price_tab    = '{vcd_pkg::PRICE_ONE_RST, vcd_pkg::PRICE_TWO_RST, vcd_pkg::PRICE_THREE_RST};
    chosen_price = '0;
    paid_total   = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_status_paths();
    test_change_breakdown();
    test_total_saturation();
    test_price_extremes();

    wait_idle();
    set_prices(vcd_pkg::PRICE_ONE_RST, vcd_pkg::PRICE_TWO_RST, vcd_pkg::PRICE_THREE_RST);
    test_random_sales(20);
    wait_idle();
    set_prices(vcd_pkg::PRICE_W'($urandom_range(1, 65535)),
               vcd_pkg::PRICE_W'($urandom_range(1, 999)),
               vcd_pkg::PRICE_W'($urandom_range(1, 9999)));
    test_random_sales(20);
    wait_idle();
    set_prices(16'd1, 16'd1, 16'd1);
    test_random_sales(10);
    wait_idle();
    set_prices(16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_random_sales(10);
    wait_idle();
    set_prices(vcd_pkg::PRICE_W'($urandom_range(1, 2000)),
               vcd_pkg::PRICE_W'($urandom_range(1, 65535)),
               vcd_pkg::PRICE_W'($urandom_range(1, 500)));
    // Final stretch runs both channels at full rate.
    quiet = 1'b1;
    test_random_sales(25);
    wait_idle();

    $display("Sent %0d request items covering %0d settlements; %0d results were checked.",
             n_items, n_settles, n_results);
    $display("Prices went through reset values, zero, one cent, full scale and random values.");
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Receiver side: random stall bursts until the final stretch.
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 14) - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    n_results = 0;
    n_errors  = 0;
  end

  always @(posedge clk) begin
    payout_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      n_results++;
      if (payout_q.size() == 0) begin
        n_errors++;
        $error("unexpected result: status %0d, denomination %0d, count %0d",
               rsp_ch.status, rsp_ch.denomination_cents, rsp_ch.item_count);
      end else begin
        want = payout_q.pop_front();
        if (rsp_ch.status !== want.status) begin
          n_errors++;
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
        end
        if (rsp_ch.change_is_note !== want.change_is_note) begin
          n_errors++;
          $error("change_is_note: expected %0d, got %0d", want.change_is_note,
                 rsp_ch.change_is_note);
        end
        if (rsp_ch.denomination_cents !== want.denomination_cents) begin
          n_errors++;
          $error("denomination_cents: expected %0d, got %0d", want.denomination_cents,
                 rsp_ch.denomination_cents);
        end
        if (rsp_ch.item_count !== want.item_count) begin
          n_errors++;
          $error("item_count: expected %0d, got %0d", want.item_count, rsp_ch.item_count);
        end
        if (rsp_ch.last !== want.last) begin
          n_errors++;
          $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
        end
      end
    end
  end

  // Watchdog: too long without any handshake on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a handshake.", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
